// ===== src/lmps_pkg.sv =====
// ----------------------------------------------------------------------------
// LED matrix PWM scanner package
// Shared geometry constants, widths and the pixel-to-color-bit function.
// ----------------------------------------------------------------------------
package lmps_pkg;

	// Panel geometry.
	localparam int ROW_LENGTH       = 384;
	localparam int ROWS_PER_QUARTER = 16;
	localparam int QUARTER_SIZE     = ROW_LENGTH * ROWS_PER_QUARTER;
	localparam int STORE_DEPTH      = 4 * QUARTER_SIZE;
	localparam int NUM_BANKS        = 4;

	// Field widths.
	localparam int ADDR_W   = 15;
	localparam int PIXEL_W  = 16;
	localparam int LEVEL_W  = 5;
	localparam int LCOUNT_W = 6;
	localparam int COLOR_W  = 6;
	localparam int ROWSEL_W = 4;

	// Derived counter widths.
	localparam int POS_W  = $clog2(QUARTER_SIZE);
	localparam int COL_W  = $clog2(ROW_LENGTH);
	localparam int ROW_W  = $clog2(ROWS_PER_QUARTER);
	localparam int BANK_W = $clog2(NUM_BANKS);

	// Reset value of the level count register.
	localparam logic [LCOUNT_W-1:0] LEVEL_COUNT_RESET = LCOUNT_W'(16);

	// Operation codes of an input item.
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	// Threshold one 565 pixel against a level: {blue, green, red}.
	function automatic logic [2:0] line_bits(input logic [PIXEL_W-1:0] px,
		input logic [LEVEL_W-1:0] lvl);
		logic [4:0] red;
		logic [5:0] green;
		logic [4:0] blue;
		red   = px[15:11];
		green = {px[10:6], 1'b0};
		blue  = px[4:0];
		line_bits = {blue > lvl, green > {1'b0, lvl}, red > lvl};
	endfunction

endpackage

// ===== src/led_matrix_pwm_scanner_unit.sv =====
// A tick transaction's result is registered in the bank read data and stage one, then in the output register.
// Throughput: one item per cycle while in_stall is low; the four quarter banks are read in parallel
// through their own read ports, and pixel writes use the separate write port.
// Reset clears the column position, the PWM level and the output pipeline,
// and sets level_count to 16. The frame store is not cleared.
// ----------------------------------------------------------------------------
// LED matrix PWM scanner
// Banked frame store with a scan engine that emits one threshold-PWM column
// per tick, with row select, latch pulse and subframe level.
// ----------------------------------------------------------------------------
module led_matrix_pwm_scanner_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic [lmps_pkg::ADDR_W-1:0]         pixel_address,
	input  logic [lmps_pkg::PIXEL_W-1:0]        pixel_value,
	// Output channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lmps_pkg::COLOR_W-1:0]        upper_colors,
	output logic [lmps_pkg::COLOR_W-1:0]        lower_colors,
	output logic [lmps_pkg::ROWSEL_W-1:0]       row_select,
	output logic                                latch_pulse,
	output logic [lmps_pkg::LEVEL_W-1:0]        subframe_level,
	// Configuration channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lmps_pkg::LCOUNT_W-1:0]       cfg_data
);

	localparam logic [lmps_pkg::ADDR_W-1:0] Q1 = lmps_pkg::ADDR_W'(lmps_pkg::QUARTER_SIZE);
	localparam logic [lmps_pkg::ADDR_W-1:0] Q2 =
		lmps_pkg::ADDR_W'(2 * lmps_pkg::QUARTER_SIZE);
	localparam logic [lmps_pkg::ADDR_W-1:0] Q3 =
		lmps_pkg::ADDR_W'(3 * lmps_pkg::QUARTER_SIZE);
	localparam logic [lmps_pkg::ADDR_W-1:0] QEND =
		lmps_pkg::ADDR_W'(lmps_pkg::STORE_DEPTH);
	localparam logic [lmps_pkg::POS_W-1:0] POS_LAST =
		lmps_pkg::POS_W'(lmps_pkg::QUARTER_SIZE - 1);
	localparam logic [lmps_pkg::COL_W-1:0] COL_LAST =
		lmps_pkg::COL_W'(lmps_pkg::ROW_LENGTH - 1);

	logic                                accept;
	logic                                tick_acc;
	logic                                wr_acc;
	logic                                s1_move;
	logic                                wr_hit;
	logic [lmps_pkg::BANK_W-1:0]         wr_bank;
	logic [lmps_pkg::ADDR_W-1:0]         wr_base;
	logic [lmps_pkg::ADDR_W-1:0]         wr_off_full;
	logic [lmps_pkg::POS_W-1:0]          wr_off;
	logic                                pos_last;
	logic [lmps_pkg::LEVEL_W-1:0]        level_next;
	logic [lmps_pkg::PIXEL_W-1:0]        rd_data [lmps_pkg::NUM_BANKS];
	logic [31:0]                         row_ext;

	logic [lmps_pkg::LCOUNT_W-1:0]       level_count_q;
	logic [lmps_pkg::POS_W-1:0]          pos_q;
	logic [lmps_pkg::COL_W-1:0]          col_q;
	logic [lmps_pkg::ROW_W-1:0]          row_q;
	logic [lmps_pkg::LEVEL_W-1:0]        level_q;

	logic                                valid_s1;
	logic [lmps_pkg::ROW_W-1:0]          row_s1;
	logic                                last_s1;
	logic [lmps_pkg::LEVEL_W-1:0]        level_s1;

	logic                                out_valid_q;
	logic [lmps_pkg::COLOR_W-1:0]        upper_colors_q;
	logic [lmps_pkg::COLOR_W-1:0]        lower_colors_q;
	logic [lmps_pkg::ROWSEL_W-1:0]       row_select_q;
	logic                                latch_pulse_q;
	logic [lmps_pkg::LEVEL_W-1:0]        subframe_level_q;

	// Handshake. Stage one moves on when the output register is free or drains.
	assign s1_move  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !s1_move;
	assign accept   = in_valid && !in_stall;
	assign tick_acc = accept && (op == lmps_pkg::OP_TICK);
	assign wr_acc   = accept && (op == lmps_pkg::OP_WRITE);
	assign cfg_ready = 1'b1;

	// Split a store address into its quarter and the offset within it.
	always_comb begin
		wr_hit = pixel_address < QEND;
		if (pixel_address >= Q3) begin
			wr_bank = lmps_pkg::BANK_W'(3);
			wr_base = Q3;
		end else if (pixel_address >= Q2) begin
			wr_bank = lmps_pkg::BANK_W'(2);
			wr_base = Q2;
		end else if (pixel_address >= Q1) begin
			wr_bank = lmps_pkg::BANK_W'(1);
			wr_base = Q1;
		end else begin
			wr_bank = lmps_pkg::BANK_W'(0);
			wr_base = '0;
		end
		wr_off_full = pixel_address - wr_base;
		wr_off      = wr_off_full[lmps_pkg::POS_W-1:0];
	end

	// One bank per quarter, all read at the current column position.
	for (genvar b = 0; b < lmps_pkg::NUM_BANKS; b++) begin : g_bank
		lmps_ram #(
			.WIDTH(lmps_pkg::PIXEL_W),
			.DEPTH(lmps_pkg::QUARTER_SIZE)
		) u_bank (
			.clk  (clk),
			.we   (wr_acc && wr_hit && (wr_bank == lmps_pkg::BANK_W'(b))),
			.waddr(wr_off),
			.wdata(pixel_value),
			.re   (tick_acc),
			.raddr(pos_q),
			.rdata(rd_data[b])
		);
	end

	// Level advance after the last column of the scan.
	always_comb begin
		pos_last   = pos_q == POS_LAST;
		level_next = level_q + lmps_pkg::LEVEL_W'(1);
		if ({1'b0, level_next} >= level_count_q) begin
			level_next = '0;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= lmps_pkg::LEVEL_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			level_count_q <= cfg_data;
		end
	end

	// Scan counters: flat position, column within the row, row and level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			level_q <= '0;
		end else if (tick_acc) begin
			if (pos_last) begin
				pos_q   <= '0;
				col_q   <= '0;
				row_q   <= '0;
				level_q <= level_next;
			end else begin
				pos_q <= pos_q + lmps_pkg::POS_W'(1);
				if (col_q == COL_LAST) begin
					col_q <= '0;
					row_q <= row_q + lmps_pkg::ROW_W'(1);
				end else begin
					col_q <= col_q + lmps_pkg::COL_W'(1);
				end
			end
		end
	end

	// Stage one waits for the bank read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			row_s1   <= row_q;
			last_s1  <= pos_last;
			level_s1 <= level_q;
		end
	end

	assign row_ext = 32'(row_s1);

	// Output register: threshold the four pixels against the level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			upper_colors_q   <= {lmps_pkg::line_bits(rd_data[1], level_s1),
				lmps_pkg::line_bits(rd_data[0], level_s1)};
			lower_colors_q   <= {lmps_pkg::line_bits(rd_data[3], level_s1),
				lmps_pkg::line_bits(rd_data[2], level_s1)};
			row_select_q     <= row_ext[lmps_pkg::ROWSEL_W-1:0];
			latch_pulse_q    <= last_s1;
			subframe_level_q <= level_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign upper_colors   = upper_colors_q;
	assign lower_colors   = lower_colors_q;
	assign row_select     = row_select_q;
	assign latch_pulse    = latch_pulse_q;
	assign subframe_level = subframe_level_q;

endmodule

// ===== src/lmps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read that holds its
// data while the read enable is low.
// ----------------------------------------------------------------------------
module lmps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
